@@ src/led_matrix_mode_sequencer_assert.svh @@
// Assertion macros for the checker file of the scanner.
`ifndef LED_MATRIX_MODE_SEQUENCER_ASSERT_SVH
`define LED_MATRIX_MODE_SEQUENCER_ASSERT_SVH

// A property checked at every rising edge outside reset.
`define LMMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A vector that must hold exactly one set bit outside reset.
`define LMMS_ASSERT_ONEHOT(lbl, clk, rst_n, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) $onehot(sig)) else $error(msg);

`endif

@@ src/lmms_pkg.sv @@
package lmms_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_ALL_ON_SCANS     = 3'd0;
	localparam logic [2:0] REG_SWEEP_SCANS      = 3'd1;
	localparam logic [2:0] REG_SLOW_SWEEP_SCANS = 3'd2;
	localparam logic [2:0] REG_ROW_HOLD_TICKS   = 3'd3;
	localparam logic [2:0] REG_DIGIT_HOLD_TICKS = 3'd4;

	// Register reset values.
	localparam logic [7:0] RST_ALL_ON_SCANS     = 8'd4;
	localparam logic [7:0] RST_SWEEP_SCANS      = 8'd50;
	localparam logic [7:0] RST_SLOW_SWEEP_SCANS = 8'd5;
	localparam logic [7:0] RST_ROW_HOLD_TICKS   = 8'd5;
	localparam logic [7:0] RST_DIGIT_HOLD_TICKS = 8'd60;

	// Display modes.
	localparam logic [2:0] MODE_ALL_ON = 3'd0;
	localparam logic [2:0] MODE_SWEEP  = 3'd1;
	localparam logic [2:0] MODE_FAST   = 3'd2;
	localparam logic [2:0] MODE_SLOW   = 3'd3;
	localparam logic [2:0] MODE_DIGITS = 3'd4;

	// Matrix geometry.
	localparam logic [2:0] NUM_COLS   = 3'd5;
	localparam logic [2:0] NUM_ROWS   = 3'd7;
	localparam logic [3:0] NUM_DIGITS = 4'd10;

	localparam logic [4:0] RING_FIRST = 5'b00001;

	// Active-low column patterns of the digits 0 to 9.
	localparam logic [7:0] DIGIT_FONT [0:9][0:4] = '{
		'{8'h41, 8'h2E, 8'h36, 8'h3A, 8'h41},
		'{8'h3F, 8'h3D, 8'h00, 8'h3F, 8'h3F},
		'{8'h3D, 8'h1E, 8'h2E, 8'h36, 8'h39},
		'{8'h5D, 8'h3E, 8'h36, 8'h36, 8'h49},
		'{8'h67, 8'h6B, 8'h6D, 8'h00, 8'h7F},
		'{8'h58, 8'h3A, 8'h3A, 8'h3A, 8'h46},
		'{8'h43, 8'h35, 8'h36, 8'h36, 8'h4F},
		'{8'h7C, 8'h7E, 8'h0E, 8'h76, 8'h78},
		'{8'h49, 8'h36, 8'h36, 8'h36, 8'h49},
		'{8'h79, 8'h36, 8'h36, 8'h56, 8'h69}
	};

	typedef struct packed {
		logic [7:0] all_on_scans;
		logic [7:0] sweep_scans;
		logic [7:0] slow_sweep_scans;
		logic [7:0] row_hold_ticks;
		logic [7:0] digit_hold_ticks;
	} lmms_cfg_t;

	typedef struct packed {
		logic [4:0] column_drive;
		logic [7:0] row_drive;
		logic       long_dwell;
		logic [2:0] mode_shown;
	} lmms_result_t;

endpackage

@@ src/lmms_cfg_regs.sv @@
module lmms_cfg_regs
	import lmms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output lmms_cfg_t  cfg
);

	lmms_cfg_t cfg_q;

	// Register file; writes to indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.all_on_scans     <= RST_ALL_ON_SCANS;
			cfg_q.sweep_scans      <= RST_SWEEP_SCANS;
			cfg_q.slow_sweep_scans <= RST_SLOW_SWEEP_SCANS;
			cfg_q.row_hold_ticks   <= RST_ROW_HOLD_TICKS;
			cfg_q.digit_hold_ticks <= RST_DIGIT_HOLD_TICKS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ALL_ON_SCANS:     cfg_q.all_on_scans     <= cfg_data;
				REG_SWEEP_SCANS:      cfg_q.sweep_scans      <= cfg_data;
				REG_SLOW_SWEEP_SCANS: cfg_q.slow_sweep_scans <= cfg_data;
				REG_ROW_HOLD_TICKS:   cfg_q.row_hold_ticks   <= cfg_data;
				REG_DIGIT_HOLD_TICKS: cfg_q.digit_hold_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/lmms_scan_core.sv @@
module lmms_scan_core
	import lmms_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step_en,
	input  lmms_cfg_t    cfg,
	output lmms_result_t result
);

	logic [2:0] mode_q, mode_n;
	logic [4:0] ring_q, ring_n;
	logic [2:0] col_q, col_n;
	logic [3:0] digit_q, digit_n;
	logic [7:0] hold_q, hold_n;
	logic [2:0] row_q, row_n;
	logic [7:0] scan_q, scan_n;
	logic       done_q, done_n;

	logic [7:0] sweep_row;
	logic [7:0] row_pat;
	logic       dwell;
	logic       change;

	// Active-low single row for the sweep modes.
	always_comb begin
		if (row_q < NUM_ROWS && col_q < NUM_COLS) begin
			sweep_row = ~(8'd1 << row_q);
		end else begin
			sweep_row = 8'd0;
		end
	end

	// Pattern for this step and the next counter values.
	always_comb begin
		mode_n  = mode_q;
		ring_n  = ring_q;
		col_n   = col_q;
		digit_n = digit_q;
		hold_n  = hold_q;
		row_n   = row_q;
		scan_n  = scan_q;
		done_n  = done_q;
		row_pat = 8'd0;
		dwell   = 1'b0;
		change  = 1'b0;

		case (mode_q)
			MODE_ALL_ON: begin
				row_pat = 8'd0;
				dwell   = 1'b1;
			end
			MODE_SWEEP, MODE_SLOW: begin
				row_pat = sweep_row;
				dwell   = (mode_q == MODE_SLOW);
				hold_n  = hold_q + 8'd1;
				if (hold_n == cfg.row_hold_ticks) begin
					row_n  = row_q + 3'd1;
					hold_n = 8'd0;
				end
				if (row_n == NUM_ROWS) begin
					row_n = 3'd0;
				end
			end
			MODE_FAST: begin
				row_pat = sweep_row;
				row_n   = row_q + 3'd1;
				if (row_n == NUM_ROWS) begin
					row_n = 3'd0;
				end
			end
			default: begin
				if (digit_q < NUM_DIGITS && col_q < NUM_COLS) begin
					row_pat = DIGIT_FONT[digit_q][col_q];
				end
				hold_n = hold_q + 8'd1;
				if (hold_n == cfg.digit_hold_ticks) begin
					hold_n  = 8'd0;
					digit_n = digit_q + 4'd1;
				end
				if (digit_n >= NUM_DIGITS) begin
					done_n  = 1'b1;
					digit_n = 4'd0;
				end
			end
		endcase

		// Column ring and index; a wrap of the index ends one scan.
		case (ring_q)
			5'b00001: ring_n = 5'b00010;
			5'b00010: ring_n = 5'b00100;
			5'b00100: ring_n = 5'b01000;
			5'b01000: ring_n = 5'b10000;
			default:  ring_n = RING_FIRST;
		endcase
		col_n = col_q + 3'd1;
		if (col_n >= NUM_COLS) begin
			col_n  = 3'd0;
			scan_n = scan_q + 8'd1;
		end

		case (mode_q)
			MODE_ALL_ON:           change = (scan_n == cfg.all_on_scans);
			MODE_SWEEP, MODE_FAST: change = (scan_n == cfg.sweep_scans);
			MODE_SLOW:             change = (scan_n == cfg.slow_sweep_scans);
			default:               change = done_n;
		endcase

		// Mode change restarts every counter.
		if (change) begin
			scan_n  = 8'd0;
			col_n   = 3'd0;
			row_n   = 3'd0;
			digit_n = 4'd0;
			hold_n  = 8'd0;
			ring_n  = RING_FIRST;
			done_n  = 1'b0;
			mode_n  = (mode_q >= MODE_DIGITS) ? MODE_ALL_ON : mode_q + 3'd1;
		end
	end

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_DIGITS;
			ring_q  <= RING_FIRST;
			col_q   <= 3'd0;
			digit_q <= 4'd0;
			hold_q  <= 8'd0;
			row_q   <= 3'd0;
			scan_q  <= 8'd0;
			done_q  <= 1'b0;
		end else if (step_en) begin
			mode_q  <= mode_n;
			ring_q  <= ring_n;
			col_q   <= col_n;
			digit_q <= digit_n;
			hold_q  <= hold_n;
			row_q   <= row_n;
			scan_q  <= scan_n;
			done_q  <= done_n;
		end
	end

	assign result.column_drive = ring_n;
	assign result.row_drive    = row_pat;
	assign result.long_dwell   = dwell;
	assign result.mode_shown   = mode_q;

endmodule

@@ src/led_matrix_mode_sequencer.sv @@
// 5x7 LED matrix scanner that steps through five display modes.
// Input channel: in_valid/in_stall carry one word, the tick bit. A word with
// tick high advances the scan by one column; a word with tick low repeats
// the previous result unchanged. Every input word yields one output word.
// Output channel: out_valid/out_stall carry column_drive (one-hot column),
// row_drive (active-low rows), long_dwell and mode_shown.
// Path: a word accepted into the input register moves on into the result
// register as soon as the result register can take it.
// Throughput: one word per cycle while out_stall is low; the scan state
// updates as a word moves from the input register into the result register.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one 8-bit register per
// cycle; write only while no word is in flight.
// Reset: the mode is digits, the column ring sits at the first column and the
// repeated result before the first advance is column 00001, rows 0, mode 4.
// Stall: while out_stall holds a waiting word, one more input word is taken
// into the input register, then in_stall rises until the output drains.
module led_matrix_mode_sequencer
	import lmms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       tick,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] column_drive,
	output logic [7:0] row_drive,
	output logic       long_dwell,
	output logic [2:0] mode_shown
);

	lmms_cfg_t    cfg;
	lmms_result_t result;
	lmms_result_t out_q;

	logic in_valid_s1;
	logic tick_s1;
	logic out_valid_q;
	logic advance;
	logic step_en;

	// The result register can take a word when empty or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = in_valid_s1 && !advance;
	assign step_en  = advance && in_valid_s1 && tick_s1;

	lmms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lmms_scan_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.cfg     (cfg),
		.result  (result)
	);

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (!in_stall) begin
			tick_s1 <= tick;
		end
	end

	// Result register; it also keeps the last result for idle ticks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q        <= 1'b0;
			out_q.column_drive <= RING_FIRST;
			out_q.row_drive    <= 8'd0;
			out_q.long_dwell   <= 1'b0;
			out_q.mode_shown   <= MODE_DIGITS;
		end else if (advance) begin
			out_valid_q <= in_valid_s1;
			if (step_en) begin
				out_q <= result;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign column_drive = out_q.column_drive;
	assign row_drive    = out_q.row_drive;
	assign long_dwell   = out_q.long_dwell;
	assign mode_shown   = out_q.mode_shown;

endmodule

@@ src/lmms_checker.sv @@
`include "led_matrix_mode_sequencer_assert.svh"

module lmms_checker
	import lmms_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [4:0] column_drive,
	input logic [7:0] row_drive,
	input logic       long_dwell,
	input logic [2:0] mode_shown
);

	// Exactly one column is ever driven.
	`LMMS_ASSERT_ONEHOT(a_col_onehot, clk, arst_n, column_drive, "column_drive is not one-hot")

	// All-rows-lit mode drives every row and asks for the long hold.
	`LMMS_ASSERT(a_all_on, clk, arst_n, mode_shown == MODE_ALL_ON |-> long_dwell && row_drive == 8'd0, "all-on mode word is wrong")

	// Only the all-on and slow sweep modes ask for the long hold.
	`LMMS_ASSERT(a_dwell, clk, arst_n, long_dwell |-> mode_shown == MODE_ALL_ON || mode_shown == MODE_SLOW, "long_dwell in a short-hold mode")

	// A stalled output word is held.
	`LMMS_ASSERT(a_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(column_drive) && $stable(row_drive) && $stable(mode_shown), "stalled word changed")

endmodule

bind led_matrix_mode_sequencer lmms_checker u_lmms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.column_drive (column_drive),
	.row_drive    (row_drive),
	.long_dwell   (long_dwell),
	.mode_shown   (mode_shown)
);
